/* src/bws_pkg.sv */
package bws_pkg;

    // fixed field widths of the streams and the register port
    localparam int PIX_BITS     = 16;
    localparam int SUM_BITS     = 16;
    localparam int ROW_BITS     = 16;
    localparam int OUT_COL_BITS = 12;
    localparam int CFG_W_BITS   = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_D_BITS   = 16;
    // position row runs past the image into the drain rows
    localparam int PROW_BITS    = ROW_BITS + 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH_IDX  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT_IDX = 1'd1;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 13'd4096;
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 16'd4096;

    // control flags that travel with one position down the pipe
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
        logic use_bot;
        logic first_row;
        logic sub_ok;
        logic col_zero;
    } t_ctl;

endpackage

/* src/bws_pix_if.sv */
interface bws_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bws_pkg::PIX_BITS-1:0] pixel;

    modport source (output valid, kind, pixel, input ready);
    modport sink   (input valid, kind, pixel, output ready);
endinterface

/* src/bws_res_if.sv */
interface bws_res_if;
    logic                             valid;
    logic                             ready;
    logic [bws_pkg::SUM_BITS-1:0]     window_sum;
    logic [bws_pkg::OUT_COL_BITS-1:0] out_col;
    logic [bws_pkg::ROW_BITS-1:0]     out_row;
    logic                             frame_last;

    modport source (output valid, window_sum, out_col, out_row, frame_last, input ready);
    modport sink   (input valid, window_sum, out_col, out_row, frame_last, output ready);
endinterface

/* src/bws_cfg_if.sv */
interface bws_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bws_pkg::CFG_IDX_BITS-1:0] index;
    logic [bws_pkg::CFG_D_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/box_window_sum_stream.sv */
// Clipped box-window sum over a raster pixel stream. One word is taken per
// clock, pixel or flush alike, unless the output is stalled, and a result
// leaves per word once the lag of HALF_HEIGHT*width + HALF_WIDTH positions has
// passed; after the last pixel of a frame, flush words drain the pending
// results, one per word, until the one marked frame_last. Where a frame holds
// fewer pixels than the lag, the block advances the missing empty positions on
// its own after the last pixel and holds the input meanwhile. The rate is set
// by the column-sum memory, which takes one read and one write-back per cycle;
// a one-entry forward covers the single column case. An accepted word passes
// the control register, the column-sum read and write-back registers and the
// row prefix line to the output register. No clearing pass is needed after
// reset or between frames: the first row of a frame treats the stored column
// sum as zero. Geometry is latched at a frame's first pixel; a width of zero
// counts as one, above MAX_WIDTH as MAX_WIDTH, and a height of zero as one.
module box_window_sum_stream #(
    parameter int HALF_WIDTH  = 3,
    parameter int HALF_HEIGHT = 3,
    parameter int MAX_WIDTH   = 4096,
    parameter int PIXEL_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bws_pix_if.sink    i_pix,
    bws_res_if.source  o_res,
    bws_cfg_if.sink    i_cfg
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int RING      = 2 * HALF_HEIGHT + 1;
    localparam int ADDR_BITS = $clog2(RING * MAX_WIDTH);
    localparam int K_BITS    = $clog2(HALF_WIDTH + 1);

    logic                          w_en;
    bws_pkg::t_ctl                 a_ctl, c_ctl;
    logic [COL_BITS-1:0]           a_col, a_ocol, c_ocol;
    logic [ADDR_BITS-1:0]          a_addr;
    logic [bws_pkg::PIX_BITS-1:0]  a_pix;
    logic [bws_pkg::ROW_BITS-1:0]  a_orow, c_orow;
    logic [K_BITS-1:0]             a_k, c_k;
    logic [bws_pkg::SUM_BITS-1:0]  c_v;

    // advance the whole pipe whenever the output register is free or drains
    assign w_en = !o_res.valid || o_res.ready;

    bws_ctrl #(
        .HALF_WIDTH (HALF_WIDTH),
        .HALF_HEIGHT(HALF_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_pix  (i_pix),
        .i_cfg  (i_cfg),
        .o_ctl  (a_ctl),
        .o_col  (a_col),
        .o_addr (a_addr),
        .o_pix  (a_pix),
        .o_ocol (a_ocol),
        .o_orow (a_orow),
        .o_k    (a_k)
    );

    // column sums and row ring: read at one stage, write back at the next
    bws_vert #(
        .HALF_WIDTH (HALF_WIDTH),
        .HALF_HEIGHT(HALF_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_vert (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_ctl  (a_ctl),
        .i_col  (a_col),
        .i_addr (a_addr),
        .i_pix  (a_pix),
        .i_ocol (a_ocol),
        .i_orow (a_orow),
        .i_k    (a_k),
        .o_ctl  (c_ctl),
        .o_v    (c_v),
        .o_ocol (c_ocol),
        .o_orow (c_orow),
        .o_k    (c_k)
    );

    // row prefix line and the output word
    bws_horz #(
        .HALF_WIDTH(HALF_WIDTH),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_horz (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_ctl  (c_ctl),
        .i_v    (c_v),
        .i_ocol (c_ocol),
        .i_orow (c_orow),
        .i_k    (c_k),
        .o_res  (o_res)
    );

endmodule

/* src/bws_ctrl.sv */
module bws_ctrl #(
    parameter int HALF_WIDTH  = 3,
    parameter int HALF_HEIGHT = 3,
    parameter int MAX_WIDTH   = 4096,
    parameter int PIXEL_BITS  = 16,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int RING       = 2 * HALF_HEIGHT + 1,
    localparam int ADDR_BITS  = $clog2(RING * MAX_WIDTH),
    localparam int K_BITS     = $clog2(HALF_WIDTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    bws_pix_if.sink                       i_pix,
    bws_cfg_if.sink                       i_cfg,
    output bws_pkg::t_ctl                 o_ctl,
    output logic [COL_BITS-1:0]           o_col,
    output logic [ADDR_BITS-1:0]          o_addr,
    output logic [bws_pkg::PIX_BITS-1:0]  o_pix,
    output logic [COL_BITS-1:0]           o_ocol,
    output logic [bws_pkg::ROW_BITS-1:0]  o_orow,
    output logic [K_BITS-1:0]             o_k
);

    localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int CW        = (WID_BITS > bws_pkg::CFG_W_BITS) ? WID_BITS : bws_pkg::CFG_W_BITS;
    localparam int LAG_BITS  = $clog2(HALF_HEIGHT * MAX_WIDTH + HALF_WIDTH + 1);
    localparam int PB        = bws_pkg::PROW_BITS;
    localparam logic [bws_pkg::PIX_BITS-1:0] PIX_MASK =
        (PIXEL_BITS >= bws_pkg::PIX_BITS) ? '1 : bws_pkg::PIX_BITS'((1 << PIXEL_BITS) - 1);
    localparam logic [ADDR_BITS-1:0] BASE_LAST = ADDR_BITS'((RING - 1) * MAX_WIDTH);

    logic [bws_pkg::CFG_W_BITS-1:0] r_cfg_w;
    logic [bws_pkg::ROW_BITS-1:0]   r_cfg_h;
    logic                           r_busy;
    logic [WID_BITS-1:0]            r_w;
    logic [bws_pkg::ROW_BITS-1:0]   r_h;
    logic [COL_BITS-1:0]            r_pcol;
    logic [PB-1:0]                  r_prow;
    logic [ADDR_BITS-1:0]           r_base;
    logic [LAG_BITS-1:0]            r_lag;
    logic [COL_BITS-1:0]            r_rc;
    logic [bws_pkg::ROW_BITS-1:0]   r_rr;
    bws_pkg::t_ctl                  r_a_ctl;
    bws_pkg::t_ctl                  n_ctl;

    logic                           fire, drain, adv, is_pix, pos, start, emit, last;
    logic                           col_end;
    logic [WID_BITS-1:0]            w_new, w_eff;
    logic [bws_pkg::ROW_BITS-1:0]   h_new;
    logic [WID_BITS:0]              kk, wm1;
    logic [K_BITS-1:0]              n_k;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = i_en && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bws_pkg::WIDTH_RESET;
            r_cfg_h <= bws_pkg::HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bws_pkg::CFG_WIDTH_IDX:  r_cfg_w <= i_cfg.data[bws_pkg::CFG_W_BITS-1:0];
                bws_pkg::CFG_HEIGHT_IDX: r_cfg_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0)
            w_new = WID_BITS'(1);
        else if (CW'(r_cfg_w) > CW'(MAX_WIDTH))
            w_new = WID_BITS'(MAX_WIDTH);
        else
            w_new = WID_BITS'(r_cfg_w);
        h_new = (r_cfg_h == '0) ? bws_pkg::ROW_BITS'(1) : r_cfg_h;

        drain   = r_busy && (r_prow >= PB'(r_h));
        // advance empty positions on our own until the first result is due
        adv     = drain && (r_lag != '0);
        fire    = i_pix.valid && i_en && !adv;
        is_pix  = !drain && !i_pix.kind;
        pos     = (fire && (drain || is_pix)) || adv;
        start   = fire && is_pix && !r_busy;
        w_eff   = start ? w_new : r_w;
        emit    = pos && r_busy && (r_lag == '0);
        col_end = WID_BITS'(r_pcol) == (w_eff - WID_BITS'(1));
        last    = emit && (WID_BITS'(r_rc) == (r_w - WID_BITS'(1)))
                       && (r_rr == (r_h - bws_pkg::ROW_BITS'(1)));

        // how far back the row's right edge lies when the window is clipped there
        kk  = (WID_BITS + 1)'(r_rc) + (WID_BITS + 1)'(HALF_WIDTH);
        wm1 = {1'b0, r_w - WID_BITS'(1)};
        n_k = (kk > wm1) ? K_BITS'(kk - wm1) : '0;

        n_ctl.valid     = pos;
        n_ctl.emit      = emit;
        n_ctl.last      = last;
        n_ctl.use_bot   = (COL_BITS + 1)'(r_rc) >= (COL_BITS + 1)'(HALF_WIDTH + 1);
        n_ctl.first_row = r_prow == '0;
        n_ctl.sub_ok    = r_prow >= PB'(2 * HALF_HEIGHT + 1);
        n_ctl.col_zero  = r_pcol == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_w     <= WID_BITS'(1);
            r_h     <= bws_pkg::ROW_BITS'(1);
            r_pcol  <= '0;
            r_prow  <= '0;
            r_base  <= '0;
            r_lag   <= '0;
            r_rc    <= '0;
            r_rr    <= '0;
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_ctl;
            if (start) begin
                r_busy <= 1'b1;
                r_w    <= w_new;
                r_h    <= h_new;
                r_lag  <= LAG_BITS'(HALF_HEIGHT * w_new + HALF_WIDTH - 1);
            end
            if (pos) begin
                if (!start && !emit)
                    r_lag <= r_lag - LAG_BITS'(1);
                if (emit) begin
                    if (WID_BITS'(r_rc) == (r_w - WID_BITS'(1))) begin
                        r_rc <= '0;
                        r_rr <= r_rr + bws_pkg::ROW_BITS'(1);
                    end else begin
                        r_rc <= r_rc + COL_BITS'(1);
                    end
                end
                if (col_end) begin
                    r_pcol <= '0;
                    r_prow <= r_prow + PB'(1);
                    r_base <= (r_base == BASE_LAST) ? '0 : r_base + ADDR_BITS'(MAX_WIDTH);
                end else begin
                    r_pcol <= r_pcol + COL_BITS'(1);
                end
                if (last) begin
                    r_busy <= 1'b0;
                    r_pcol <= '0;
                    r_prow <= '0;
                    r_base <= '0;
                    r_lag  <= '0;
                    r_rc   <= '0;
                    r_rr   <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_col  <= r_pcol;
            o_addr <= r_base + ADDR_BITS'(r_pcol);
            o_pix  <= drain ? '0 : (i_pix.pixel & PIX_MASK);
            o_ocol <= r_rc;
            o_orow <= r_rr;
            o_k    <= n_k;
        end
    end

    assign o_ctl = r_a_ctl;

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_prow == '0 && r_pcol == '0 && r_rr == '0 && r_rc == '0))
        else $error("counters not cleared while idle");
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_ctl.last |-> (r_a_ctl.emit && r_a_ctl.valid))
        else $error("frame end without a result");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_a_ctl.valid && r_a_ctl.last))
        else $error("frame closed without its final result");
`endif

endmodule

/* src/bws_vert.sv */
module bws_vert #(
    parameter int HALF_WIDTH  = 3,
    parameter int HALF_HEIGHT = 3,
    parameter int MAX_WIDTH   = 4096,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int RING       = 2 * HALF_HEIGHT + 1,
    localparam int ADDR_BITS  = $clog2(RING * MAX_WIDTH),
    localparam int K_BITS     = $clog2(HALF_WIDTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  bws_pkg::t_ctl                 i_ctl,
    input  logic [COL_BITS-1:0]           i_col,
    input  logic [ADDR_BITS-1:0]          i_addr,
    input  logic [bws_pkg::PIX_BITS-1:0]  i_pix,
    input  logic [COL_BITS-1:0]           i_ocol,
    input  logic [bws_pkg::ROW_BITS-1:0]  i_orow,
    input  logic [K_BITS-1:0]             i_k,
    output bws_pkg::t_ctl                 o_ctl,
    output logic [bws_pkg::SUM_BITS-1:0]  o_v,
    output logic [COL_BITS-1:0]           o_ocol,
    output logic [bws_pkg::ROW_BITS-1:0]  o_orow,
    output logic [K_BITS-1:0]             o_k
);

    localparam int SB = bws_pkg::SUM_BITS;

    logic [SB-1:0]                 m_col [MAX_WIDTH];
    logic [bws_pkg::PIX_BITS-1:0]  m_row [RING * MAX_WIDTH];

    logic [SB-1:0]                 r_cs_rd;
    logic [bws_pkg::PIX_BITS-1:0]  r_rs_rd;
    bws_pkg::t_ctl                 r_b_ctl, r_c_ctl;
    logic [COL_BITS-1:0]           r_b_col, r_b_ocol, r_c_ocol;
    logic [ADDR_BITS-1:0]          r_b_addr;
    logic [bws_pkg::PIX_BITS-1:0]  r_b_pix;
    logic [bws_pkg::ROW_BITS-1:0]  r_b_orow, r_c_orow;
    logic [K_BITS-1:0]             r_b_k, r_c_k;
    logic                          r_byp;
    logic [SB-1:0]                 r_byp_v, r_c_v;
    logic [SB-1:0]                 old_sum, sub_pix, n_v;

    // read-modify-write: the column sum gains the new row and drops the oldest
    always_comb begin
        old_sum = r_b_ctl.first_row ? '0 : (r_byp ? r_byp_v : r_cs_rd);
        sub_pix = r_b_ctl.sub_ok ? SB'(r_rs_rd) : '0;
        n_v     = old_sum + SB'(r_b_pix) - sub_pix;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.valid) begin
                r_cs_rd <= m_col[i_col];
                r_rs_rd <= m_row[i_addr];
            end
            if (r_b_ctl.valid) begin
                m_col[r_b_col]  <= n_v;
                m_row[r_b_addr] <= r_b_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_byp   <= 1'b0;
        end else if (i_en) begin
            r_b_ctl <= i_ctl;
            r_c_ctl <= r_b_ctl;
            // forward the sum written at the same edge the next read sampled
            r_byp   <= r_b_ctl.valid && i_ctl.valid && (r_b_col == i_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_col  <= i_col;
            r_b_addr <= i_addr;
            r_b_pix  <= i_pix;
            r_b_ocol <= i_ocol;
            r_b_orow <= i_orow;
            r_b_k    <= i_k;
            r_byp_v  <= n_v;
            r_c_v    <= n_v;
            r_c_ocol <= r_b_ocol;
            r_c_orow <= r_b_orow;
            r_c_k    <= r_b_k;
        end
    end

    assign o_ctl  = r_c_ctl;
    assign o_v    = r_c_v;
    assign o_ocol = r_c_ocol;
    assign o_orow = r_c_orow;
    assign o_k    = r_c_k;

endmodule

/* src/bws_horz.sv */
module bws_horz #(
    parameter int HALF_WIDTH  = 3,
    parameter int MAX_WIDTH   = 4096,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int K_BITS     = $clog2(HALF_WIDTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  bws_pkg::t_ctl                 i_ctl,
    input  logic [bws_pkg::SUM_BITS-1:0]  i_v,
    input  logic [COL_BITS-1:0]           i_ocol,
    input  logic [bws_pkg::ROW_BITS-1:0]  i_orow,
    input  logic [K_BITS-1:0]             i_k,
    bws_res_if.source                     o_res
);

    localparam int SB   = bws_pkg::SUM_BITS;
    localparam int LINE = 2 * HALF_WIDTH + 2;

    // row prefix sums of the column sums, newest first
    logic [SB-1:0]                r_line [LINE];
    logic                         r_d_valid;
    logic                         r_d_last, r_d_use_bot;
    logic [K_BITS-1:0]            r_d_k;
    logic [COL_BITS-1:0]          r_d_ocol;
    logic [bws_pkg::ROW_BITS-1:0] r_d_orow;
    logic [SB-1:0]                n_p;

    assign n_p = (i_ctl.col_zero ? '0 : r_line[0]) + i_v;

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid) begin
            r_line[0] <= n_p;
            for (int i = 1; i < LINE; i++)
                r_line[i] <= r_line[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            o_res.valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid   <= i_ctl.valid && i_ctl.emit;
            o_res.valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_last    <= i_ctl.last;
            r_d_use_bot <= i_ctl.use_bot;
            r_d_k       <= i_k;
            r_d_ocol    <= i_ocol;
            r_d_orow    <= i_orow;
            o_res.window_sum <= r_line[r_d_k] - (r_d_use_bot ? r_line[LINE-1] : '0);
            o_res.out_col    <= bws_pkg::OUT_COL_BITS'(r_d_ocol);
            o_res.out_row    <= r_d_orow;
            o_res.frame_last <= r_d_last;
        end
    end

endmodule

/* tb/sv/bws_checker.sv */
`timescale 1ns / 100ps

// Watches the pixel, result and register channels, predicts every window sum
// and compares each result word with the oldest prediction.
module bws_checker #(
    parameter int HALF_WIDTH  = 3,
    parameter int HALF_HEIGHT = 3,
    parameter int MAX_WIDTH   = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bws_pix_if   i_pix,
    bws_res_if   i_res,
    bws_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);
    import bws_pkg::*;

    localparam int RING_ROWS = 2 * HALF_HEIGHT + HALF_WIDTH + 1;

    typedef struct packed {
        logic [SUM_BITS-1:0]     sum;
        logic [OUT_COL_BITS-1:0] col;
        logic [ROW_BITS-1:0]     row;
        logic                    last;
    } t_window_result;

    logic [PIX_BITS-1:0] pixel_ring [RING_ROWS*MAX_WIDTH];
    t_window_result      sums_due [$];

    logic [CFG_W_BITS-1:0] reg_width;
    logic [ROW_BITS-1:0]   reg_height;
    int unsigned frame_cols, frame_rows;
    int unsigned next_in_col, next_in_row, next_out_col, next_out_row;

    assign o_pending = sums_due.size();

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d (row %0d col %0d)",
                 what, got, want, i_res.out_row, i_res.out_col);
        o_errors++;
    endtask

    function automatic logic [SUM_BITS-1:0] clipped_sum(input int unsigned r,
                                                        input int unsigned c);
        int unsigned y0, y1, x0, x1;
        logic [SUM_BITS-1:0] acc;
        y0  = (r >= HALF_HEIGHT) ? r - HALF_HEIGHT : 0;
        y1  = (r + HALF_HEIGHT <= frame_rows - 1) ? r + HALF_HEIGHT : frame_rows - 1;
        x0  = (c >= HALF_WIDTH) ? c - HALF_WIDTH : 0;
        x1  = (c + HALF_WIDTH <= frame_cols - 1) ? c + HALF_WIDTH : frame_cols - 1;
        acc = '0;
        for (int unsigned y = y0; y <= y1; y++)
            for (int unsigned x = x0; x <= x1; x++)
                acc += pixel_ring[(y % RING_ROWS) * MAX_WIDTH + x];
        return acc;
    endfunction

    // queue the next result position and advance, closing the frame at its end
    task automatic push_window_sum();
        t_window_result w;
        w.sum  = clipped_sum(next_out_row, next_out_col);
        w.col  = next_out_col[OUT_COL_BITS-1:0];
        w.row  = next_out_row[ROW_BITS-1:0];
        w.last = 1'b0;
        next_out_col++;
        if (next_out_col >= frame_cols) begin
            next_out_col = 0;
            next_out_row++;
        end
        if (next_out_row >= frame_rows) begin
            w.last       = 1'b1;
            next_in_col  = 0;
            next_in_row  = 0;
            next_out_col = 0;
            next_out_row = 0;
        end
        sums_due.push_back(w);
    endtask

    task automatic predict_word(input logic is_flush, input logic [PIX_BITS-1:0] pix);
        logic frame_idle;
        longint unsigned pos, lag;
        frame_idle = next_in_col == 0 && next_in_row == 0 &&
                     next_out_col == 0 && next_out_row == 0;
        if (!frame_idle && next_in_row >= frame_rows) begin
            push_window_sum();
        end else if (!is_flush) begin
            if (frame_idle) begin
                frame_cols = (reg_width == 0) ? 1 : reg_width;
                if (frame_cols > MAX_WIDTH)
                    frame_cols = MAX_WIDTH;
                frame_rows = (reg_height == 0) ? 1 : reg_height;
            end
            pixel_ring[(next_in_row % RING_ROWS) * MAX_WIDTH + next_in_col] = pix;
            pos = longint'(next_in_row) * frame_cols + next_in_col;
            next_in_col++;
            if (next_in_col >= frame_cols) begin
                next_in_col = 0;
                next_in_row++;
            end
            lag = longint'(HALF_HEIGHT) * frame_cols + HALF_WIDTH;
            if (pos >= lag)
                push_window_sum();
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result w;
        if (!i_rst_n) begin
            reg_width    = WIDTH_RESET;
            reg_height   = HEIGHT_RESET;
            frame_cols   = 1;
            frame_rows   = 1;
            next_in_col  = 0;
            next_in_row  = 0;
            next_out_col = 0;
            next_out_row = 0;
            sums_due.delete();
        end else begin
            // compare before predicting: a word accepted now cannot leave this edge
            if (i_res.valid && i_res.ready) begin
                if (sums_due.size() == 0) begin
                    report_mismatch("unexpected result", i_res.window_sum, 0);
                end else begin
                    w = sums_due.pop_front();
                    o_checked++;
                    if (i_res.window_sum !== w.sum)
                        report_mismatch("window_sum", i_res.window_sum, w.sum);
                    if (i_res.out_col !== w.col)
                        report_mismatch("out_col", i_res.out_col, w.col);
                    if (i_res.out_row !== w.row)
                        report_mismatch("out_row", i_res.out_row, w.row);
                    if (i_res.frame_last !== w.last)
                        report_mismatch("frame_last", i_res.frame_last, w.last);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_WIDTH_IDX)
                    reg_width = i_cfg.data[CFG_W_BITS-1:0];
                else if (i_cfg.index == CFG_HEIGHT_IDX)
                    reg_height = i_cfg.data;
            end
            if (i_pix.valid && i_pix.ready)
                predict_word(i_pix.kind, i_pix.pixel);
        end
    end

    initial begin
        o_errors  = 0;
        o_checked = 0;
    end
endmodule

/* tb/sv/tb_box_window_sum_stream.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for box_window_sum_stream. The checker beside the
// block does all prediction; this module only feeds frames, writes geometry
// between frames and decides pass or fail.
module tb_box_window_sum_stream;
    import bws_pkg::*;

    localparam int HW         = 3;
    localparam int HH         = 3;
    localparam int MAXW       = 4096;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int KIND_PIXEL = 0;
    localparam int KIND_FLUSH = 1;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, checked;
    int   cycles;
    int   send_idle_pct, recv_stall_pct;
    int   frames_run, pixels_sent, flushes_sent;

    bws_pix_if pix ();
    bws_res_if res ();
    bws_cfg_if cfg ();

    box_window_sum_stream #(
        .HALF_WIDTH (HW),
        .HALF_HEIGHT(HH),
        .MAX_WIDTH  (MAXW),
        .PIXEL_BITS (PIX_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix.sink),
        .o_res  (res.source),
        .i_cfg  (cfg.sink)
    );

    bws_checker #(
        .HALF_WIDTH (HW),
        .HALF_HEIGHT(HH),
        .MAX_WIDTH  (MAXW)
    ) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (pix),
        .i_res    (res),
        .i_cfg    (cfg),
        .o_errors (errors),
        .o_pending(pending),
        .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hold every input known from time zero
    initial begin
        i_rst_n    = 1'b0;
        pix.valid  = 1'b0;
        pix.kind   = 1'b0;
        pix.pixel  = '0;
        cfg.valid  = 1'b0;
        cfg.index  = CFG_WIDTH_IDX;
        cfg.data   = '0;
        res.ready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk)
        res.ready <= ($urandom_range(99) >= recv_stall_pct);

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("box_window_sum_stream verification failed");
            $finish;
        end
    end
    initial cycles = 0;

    // offer one word, idling first at the sender's rate; leave valid high
    task automatic send_word(input int kind, input logic [PIX_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.kind  <= kind[0];
        pix.pixel <= value;
        do @(posedge i_clk); while (!pix.ready);
        if (kind == KIND_FLUSH)
            flushes_sent++;
        else
            pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_D_BITS-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // drop valid, let every result drain, then give the pipe time to settle
    task automatic wait_drained();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [PIX_BITS-1:0] pick_pixel();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return PIX_BITS'($urandom);
        endcase
    endfunction

    // one frame: pixels with stray flushes mixed in, then the drain words,
    // some of them pixels that stand in for flushes
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int mode, input bit mixed);
        int unsigned cols, rows, total, lag, drain;
        int pct [4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{21, 21}};
        cols  = (w == 0) ? 1 : ((w > MAXW) ? MAXW : w);
        rows  = (h == 0) ? 1 : h;
        total = cols * rows;
        lag   = HH * cols + HW;
        drain = (total < lag) ? total : lag;
        send_idle_pct  = pct[mode][0];
        recv_stall_pct = pct[mode][1];
        write_reg(CFG_WIDTH_IDX, CFG_D_BITS'(w));
        write_reg(CFG_HEIGHT_IDX, CFG_D_BITS'(h));
        // flush with no frame open: ignored
        if (mixed && $urandom_range(1))
            send_word(KIND_FLUSH, PIX_BITS'($urandom));
        for (int unsigned n = 0; n < total; n++) begin
            // flush while pixels are still due: ignored
            if (mixed && n != 0 && $urandom_range(9) == 0)
                send_word(KIND_FLUSH, PIX_BITS'($urandom));
            send_word(KIND_PIXEL, mixed ? pick_pixel() : PIX_BITS'($urandom));
        end
        for (int unsigned n = 0; n < drain; n++)
            send_word((mixed && $urandom_range(3) == 0) ? KIND_PIXEL : KIND_FLUSH,
                      PIX_BITS'($urandom));
        // frame closed: further flushes give nothing
        if (mixed)
            repeat ($urandom_range(2)) send_word(KIND_FLUSH, '1);
        frames_run++;
        wait_drained();
    endtask

    initial begin
        int mode;
        frames_run   = 0;
        pixels_sent  = 0;
        flushes_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate geometry, a tall single column, extreme pixel values
        run_frame(1, 1, 0, 1'b1);
        run_frame(0, 0, 0, 1'b1);
        run_frame(4, 3, 3, 1'b1);
        run_frame(7, 7, 0, 1'b1);
        run_frame(1, 40, 0, 1'b0);
        run_frame(2, 9, 0, 1'b1);

        // random: small frames under every idling pattern
        mode = 0;
        while (pixels_sent < 400) begin
            run_frame($urandom_range(12), $urandom_range(10), mode, 1'b1);
            mode = (mode + 1) % 4;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("ran %0d frames: %0d pixel words, %0d flush words, %0d results checked",
                 frames_run, pixels_sent, flushes_sent, checked);
        $display("geometry from 1x1 to 12x10 plus zero sizes and a 1x40 column, "
                 , "four idling patterns");
        if (errors == 0)
            $display("box_window_sum_stream verification clean");
        else
            $display("box_window_sum_stream verification failed");
        $finish;
    end
endmodule
